// ----- hw/rtl/swm_pkg.sv -----
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

  // passed from each cell to the one above it
  typedef struct packed {
    logic removed_below;
    logic greater;
    logic valid;
  } swm_link_t;

endpackage

// ----- hw/rtl/swm_cell.sv -----
module swm_cell
  import swm_pkg::*;
#(
  parameter int W     = 32,
  parameter int AW    = 6,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wipe,
  input  logic                 enable,
  input  logic                 clear,
  input  logic                 full,
  input  logic [AW-1:0]        oldest_age,
  input  logic [AW-1:0]        lo_pos,
  input  logic [AW-1:0]        hi_pos,
  input  logic signed [W-1:0]  sample,
  input  logic signed [W-1:0]  up_value,
  input  logic                 up_valid,
  input  logic [AW-1:0]        up_age,
  input  swm_link_t            link_in,
  input  logic signed [W-1:0]  lo_cvalue,
  input  logic [AW-1:0]        lo_cage,
  output logic signed [W-1:0]  value,
  output logic                 valid,
  output logic [AW-1:0]        age,
  output swm_link_t            link_out,
  output logic signed [W-1:0]  cvalue,
  output logic [AW-1:0]        cage,
  output logic [W-1:0]         lo_tap,
  output logic [W-1:0]         hi_tap
);

  logic my_valid;
  logic above_valid;
  logic oldest;
  logic removed;
  logic cvalid;
  logic greater;

  assign my_valid    = valid & ~clear;
  assign above_valid = up_valid & ~clear;
  assign oldest      = my_valid & full & (age == oldest_age);
  assign removed     = link_in.removed_below | oldest;

  // window after the oldest sample is taken out
  assign cvalue  = removed ? up_value : value;
  assign cvalid  = removed ? above_valid : my_valid;
  assign cage    = removed ? up_age : age;
  assign greater = ~cvalid | (cvalue > sample);

  assign link_out = '{removed_below: removed, greater: greater, valid: cvalid};

  assign lo_tap = (lo_pos == AW'(INDEX)) ? value : '0;
  assign hi_tap = (hi_pos == AW'(INDEX)) ? value : '0;

  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      valid <= 1'b0;
    end else if (enable) begin
      if (link_in.greater) begin
        valid <= link_in.valid;
      end else if (greater) begin
        valid <= 1'b1;
      end else begin
        valid <= cvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      if (link_in.greater) begin
        value <= lo_cvalue;
        age   <= lo_cage + AW'(1);
      end else if (greater) begin
        value <= sample;
        age   <= '0;
      end else begin
        value <= cvalue;
        age   <= cage + AW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/swm_tap.sv -----
module swm_tap
  import swm_pkg::*;
#(
  parameter int W = 32,
  parameter int N = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                enable,
  input  logic                in_valid,
  input  logic [N-1:0][W-1:0] lo_taps,
  input  logic [N-1:0][W-1:0] hi_taps,
  output logic                result_valid,
  output logic signed [W:0]   result
);

  localparam int GROUP = 8;
  localparam int NG    = (N + GROUP - 1) / GROUP;

  logic [NG-1:0][W-1:0] group_lo;
  logic [NG-1:0][W-1:0] group_hi;
  logic [NG-1:0][W-1:0] stage_lo;
  logic [NG-1:0][W-1:0] stage_hi;
  logic                 stage_valid;
  logic [W-1:0]         sel_lo;
  logic [W-1:0]         sel_hi;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      group_lo[g] = '0;
      group_hi[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < N) begin
          group_lo[g] = group_lo[g] | lo_taps[g * GROUP + j];
          group_hi[g] = group_hi[g] | hi_taps[g * GROUP + j];
        end
      end
    end
  end

  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int g = 0; g < NG; g++) begin
      sel_lo = sel_lo | stage_lo[g];
      sel_hi = sel_hi | stage_hi[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else if (enable) begin
      stage_valid  <= in_valid;
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      stage_lo <= group_lo;
      stage_hi <= group_hi;
      result   <= $signed({sel_lo[W-1], sel_lo}) + $signed({sel_hi[W-1], sel_hi});
    end
  end

endmodule

// ----- hw/rtl/sliding_window_median.sv -----
// Running median filter over the last window_size samples.
// Input stream: s_tdata carries the signed sample, s_tuser the restart flag,
// which empties the window before that sample enters.
// Output stream: m_tdata carries twice the median (sum of the two middle
// values), one result per sample once window_size samples have arrived
// since the last restart or configuration write.
// cfg_we/cfg_wdata write window_size (0 acts as 1, values above MAX_WINDOW
// act as MAX_WINDOW) and empty the window; write only while idle.
// The window is a row of MAX_WINDOW sorted cells; each request removes the
// oldest sample once the window is full and inserts the new one through the
// combinational chain. Throughput: one sample per cycle while the pipe is not
// held. Each result goes through cell update, tap select, then add into m_tdata.
// While a result waits with m_tready low the whole pipe holds and s_tready
// drops with it; with no result waiting the pipe keeps moving.
// Reset empties the window and sets window_size to 3; no clearing pass.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // sample
  input  logic                 s_tuser,                // restart
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [((SAMPLE_WIDTH+8)/8)*8-1:0] m_tdata    // median_times_two
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int N  = MAX_WINDOW;
  localparam int AW = $clog2(N);
  localparam int KW = $clog2(N + 1);
  localparam int OW = ((SAMPLE_WIDTH + 8) / 8) * 8;

  logic [CFG_WIDTH-1:0] window_size;
  logic [KW-1:0]        k;
  logic [KW-1:0]        fill;
  logic [KW-1:0]        fill_start;
  logic [KW-1:0]        fill_next;
  logic                 full;
  logic                 advance;
  logic                 accept;
  logic                 produced;
  logic [AW-1:0]        oldest_age;
  logic [AW-1:0]        lo_pos;
  logic [AW-1:0]        hi_pos;
  logic signed [W-1:0]  sample;
  logic signed [W:0]    result;

  logic signed [W-1:0]  value  [N+1];
  logic                 valid  [N+1];
  logic [AW-1:0]        age    [N+1];
  swm_link_t            link   [N+1];
  logic signed [W-1:0]  cvalue [N+1];
  logic [AW-1:0]        cage   [N+1];
  logic [N-1:0][W-1:0]  lo_taps;
  logic [N-1:0][W-1:0]  hi_taps;
  logic [N-1:0]         valid_vec;

  assign sample  = $signed(s_tdata[W-1:0]);
  assign advance = ~m_tvalid | m_tready;
  assign s_tready = advance;
  assign accept  = s_tvalid & advance;

  always_comb begin
    if (window_size == '0) begin
      k = KW'(1);
    end else if (32'(window_size) > N) begin
      k = KW'(N);
    end else begin
      k = KW'(window_size);
    end
  end

  assign oldest_age = AW'(k - KW'(1));
  assign lo_pos     = AW'((k - KW'(1)) >> 1);
  assign hi_pos     = AW'(k >> 1);
  assign fill_start = s_tuser ? '0 : fill;
  assign full       = (fill_start == k);
  assign fill_next  = full ? k : fill_start + KW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      produced <= 1'b0;
    end else if (advance) begin
      produced <= accept & (fill_next == k);
    end
  end

  assign link[0]     = '{removed_below: 1'b0, greater: 1'b0, valid: 1'b0};
  assign cvalue[0]   = '0;
  assign cage[0]     = '0;
  assign value[N]    = '0;
  assign valid[N]    = 1'b0;
  assign age[N]      = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_cell #(
      .W    (W),
      .AW   (AW),
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .wipe      (cfg_we),
      .enable    (accept),
      .clear     (s_tuser),
      .full      (full),
      .oldest_age(oldest_age),
      .lo_pos    (lo_pos),
      .hi_pos    (hi_pos),
      .sample    (sample),
      .up_value  (value[i+1]),
      .up_valid  (valid[i+1]),
      .up_age    (age[i+1]),
      .link_in   (link[i]),
      .lo_cvalue (cvalue[i]),
      .lo_cage   (cage[i]),
      .value     (value[i]),
      .valid     (valid[i]),
      .age       (age[i]),
      .link_out  (link[i+1]),
      .cvalue    (cvalue[i+1]),
      .cage      (cage[i+1]),
      .lo_tap    (lo_taps[i]),
      .hi_tap    (hi_taps[i])
    );
    assign valid_vec[i] = valid[i];
  end

  swm_tap #(
    .W(W),
    .N(N)
  ) u_tap (
    .clk         (clk),
    .rst         (rst),
    .enable      (advance),
    .in_valid    (produced),
    .lo_taps     (lo_taps),
    .hi_taps     (hi_taps),
    .result_valid(m_tvalid),
    .result      (result)
  );

  assign m_tdata = OW'($unsigned(result));

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= k)
    else $error("fill exceeds window size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("cell valid count differs from fill");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst) cfg_we |=> fill == '0)
    else $error("config write did not empty window");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser && !cfg_we |=> fill == KW'(1))
    else $error("restart did not leave one sample");

endmodule

// ----- tb/sliding_window_median_tb.sv -----
module sliding_window_median_tb
  import swm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN = 64;
  localparam int SW = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;  // sample
  logic                 s_tuser = 1'b0;  // restart
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;  // median_times_two, zero padding

  sliding_window_median #(
    .MAX_WINDOW  (MAX_WIN),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [CFG_WIDTH-1:0] window_reg = WINDOW_SIZE_RESET;
  logic signed [SW-1:0] history [MAX_WIN];
  logic signed [SW-1:0] ranked [MAX_WIN];
  int                   held = 0;
  int                   wr_slot = 0;
  logic signed [SW:0]   median_x2_q [$];

  int   error_count = 0;
  logic no_idle = 1'b0;
  logic hold_off = 1'b0;
  event hold_off_go;
  int   stall_left = 0;

  function automatic int active_window();
    if (window_reg == 0) return 1;
    if (window_reg > MAX_WIN) return MAX_WIN;
    return int'(window_reg);
  endfunction

  function automatic void predict_median(input logic signed [SW-1:0] value, input bit restart);
    int k;
    int oldest;
    int i;
    int pos;
    logic signed [SW:0] twice;
    k = active_window();
    if (restart) begin
      held = 0;
      wr_slot = 0;
    end
    if (held >= k) begin
      oldest = (wr_slot + MAX_WIN - held) % MAX_WIN;
      for (i = 0; i < held; i++)
        if (ranked[i] == history[oldest]) break;
      if (i < held) begin
        while (i + 1 < held) begin
          ranked[i] = ranked[i + 1];
          i++;
        end
        held--;
      end
    end
    pos = held;
    while (pos > 0 && ranked[pos - 1] > value) begin
      ranked[pos] = ranked[pos - 1];
      pos--;
    end
    ranked[pos] = value;
    held++;
    history[wr_slot] = value;
    wr_slot = (wr_slot + 1) % MAX_WIN;
    if (held >= k) begin
      twice = ranked[k / 2] + ranked[(k - 1) / 2];
      median_x2_q = {median_x2_q, twice};
    end
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 6)) - 32'd3;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) |
                      32'($urandom_range(0, 15));
    endcase
  endfunction

  // valid is left high after a request; pause_sender must run before any wait
  task automatic send_sample(input logic [SW-1:0] value, input bit restart);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    predict_median(value, restart);
  endtask

  task automatic pause_sender();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    int n;
    int ready_cycles;
    pause_sender();
    n = 0;
    while (median_x2_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (median_x2_q.size() != 0) begin
      $error("%0d median results never arrived", median_x2_q.size());
      error_count++;
      median_x2_q.delete();
    end
    // let requests that give no result leave the pipe
    ready_cycles = 0;
    while (ready_cycles < 4) begin
      @(posedge clk);
      if (m_tready) ready_cycles++;
    end
  endtask

  task automatic set_window_size(input logic [CFG_WIDTH-1:0] value);
    wait_drained();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_reg = value;
    held = 0;
    wr_slot = 0;
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 6) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial forever begin
    @(hold_off_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result checker
  always @(posedge clk) begin
    logic signed [SW:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (median_x2_q.size() == 0) begin
        $error("unexpected result: median_times_two actual %0d", $signed(m_tdata[SW:0]));
        error_count++;
      end else begin
        want = median_x2_q.pop_front();
        if (m_tdata[SW:0] !== want) begin
          $error("median_times_two mismatch: expected %0d, actual %0d",
                 want, $signed(m_tdata[SW:0]));
          error_count++;
        end
      end
    end
  end

  task automatic test_directed_extremes();
    // reset window of 3
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFE, 1'b0);
    send_sample(32'hAAAA_5555, 1'b0);
    send_sample(32'h5555_AAAA, 1'b0);
    send_sample(32'h0, 1'b1);
    send_sample(32'h0, 1'b0);
    send_sample(32'h0, 1'b0);
    send_sample(32'h0, 1'b0);
  endtask

  task automatic test_window_sizes();
    logic [CFG_WIDTH-1:0] sizes [8] = '{7'd1, 7'd0, 7'd2, 7'd4, 7'd64, 7'd65, 7'd127, 7'd63};
    int k;
    foreach (sizes[s]) begin
      set_window_size(sizes[s]);
      k = active_window();
      repeat (k + 8) send_sample(pick_sample(), 1'b0);
    end
  endtask

  task automatic test_duplicates();
    set_window_size(7'd5);
    repeat (40) send_sample(32'($urandom_range(0, 3)), 1'b0);
    set_window_size(7'd6);
    repeat (40) send_sample($urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_restart();
    set_window_size(7'd4);
    repeat (60) send_sample(pick_sample(), $urandom_range(0, 5) == 0);
  endtask

  task automatic test_backpressure();
    set_window_size(7'd4);
    -> hold_off_go;
    repeat (40) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random();
    int n;
    repeat (6) begin
      if ($urandom_range(0, 3) == 0) set_window_size(7'($urandom_range(0, 127)));
      else set_window_size(7'($urandom_range(1, 9)));
      n = $urandom_range(40, 60);
      repeat (n) send_sample(pick_sample(), $urandom_range(0, 49) == 0);
    end
  endtask

  task automatic test_no_idle();
    set_window_size(7'd5);
    no_idle <= 1'b1;
    repeat (100) send_sample(pick_sample(), $urandom_range(0, 49) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_window_sizes();
    test_duplicates();
    test_restart();
    test_backpressure();
    test_random();
    test_no_idle();
    wait_drained();
    if (error_count == 0) begin
      $display("sliding_window_median_tb passed");
    end else begin
      $display("sliding_window_median_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sliding_window_median_tb failed");
    $finish;
  end

endmodule
